[sv/stb_pkg.sv]
package stb_pkg;

	// Field widths of the request and result items.
	localparam int CMD_W      = 4;
	localparam int IDX_W      = 4;
	localparam int VAL_W      = 32;
	localparam int STAT_W     = 2;
	localparam int SLOT_W     = 4;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 72;

	// Command codes carried in s_tuser.
	localparam logic [CMD_W-1:0] CMD_TICK       = 4'd0;
	localparam logic [CMD_W-1:0] CMD_CREATE     = 4'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE     = 4'd2;
	localparam logic [CMD_W-1:0] CMD_START      = 4'd3;
	localparam logic [CMD_W-1:0] CMD_STOP       = 4'd4;
	localparam logic [CMD_W-1:0] CMD_RESET      = 4'd5;
	localparam logic [CMD_W-1:0] CMD_SET_AUTO   = 4'd6;
	localparam logic [CMD_W-1:0] CMD_SET_RELOAD = 4'd7;
	localparam logic [CMD_W-1:0] CMD_LOAD_CD    = 4'd8;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_FREE  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_USED = 2'd2;

	// Result kinds carried in m_tuser.
	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

endpackage

[sv/software_timer_bank_unit.sv]
// Channel | Direction | Handshake        | Contents
// s_      | in        | s_tvalid/tready  | tuser: command; tdata: index, value, flags
// m_      | out       | m_tvalid/tready  | tuser: kind; tlast: last; tdata: status .. count
//
// A tick runs the slot sweep, which reads the count and reload memories once
// per slot. Other commands pass through the command state.
// Reset clears the flag bits, the tick counter and the countdown at once.
// A stalled result freezes the sweep; a request is taken while a result waits.
module software_timer_bank_unit #(
	parameter int TIMER_SLOTS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// timer_index[3:0], value[35:4], auto_reload[36], start_now[37], zero[39:38]
	input  logic [stb_pkg::IN_DATA_W-1:0]   s_tdata,
	// command[3:0]
	input  logic [stb_pkg::CMD_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status[1:0], slot[5:2], system_time[37:6], countdown_now[69:38], zero[71:70]
	output logic [stb_pkg::OUT_DATA_W-1:0]  m_tdata,
	// kind[0]
	output logic                            m_tuser,
	output logic                            m_tlast
);

	import stb_pkg::*;

	localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(TIMER_SLOTS + 1);
	localparam int EW = (CW > IDX_W) ? CW : IDX_W;
	localparam int SW = (AW > SLOT_W) ? AW : SLOT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMD,
		S_TICK
	} state_t;

	state_t state_q;

	// Request fields.
	logic [IDX_W-1:0] in_idx;
	logic [VAL_W-1:0] in_val;
	logic             in_auto;
	logic             in_start;
	logic [EW-1:0]    in_idx_ext;
	logic             in_idx_ok;

	assign in_idx     = s_tdata[3:0];
	assign in_val     = s_tdata[35:4];
	assign in_auto    = s_tdata[36];
	assign in_start   = s_tdata[37];
	assign in_idx_ext = EW'(in_idx);
	assign in_idx_ok  = in_idx_ext < EW'(TIMER_SLOTS);

	// Latched request.
	logic [CMD_W-1:0] cmd_q;
	logic [AW-1:0]    idx_q;
	logic             idx_ok_q;
	logic [VAL_W-1:0] val_q;
	logic             auto_q;
	logic             start_q;

	// Bank state held in flip-flops.
	logic [TIMER_SLOTS-1:0] used_q;
	logic [TIMER_SLOTS-1:0] en_q;
	logic [TIMER_SLOTS-1:0] auto_en_q;
	logic [VAL_W-1:0]       tick_total_q;
	logic [VAL_W-1:0]       countdown_q;

	// Sweep pointer and the slot whose memory data is returning.
	logic [CW-1:0] ptr_q;
	logic [AW-1:0] idx_s1;
	logic          v_s1;

	// Output register.
	logic              out_valid_q;
	logic              out_kind_q;
	logic [STAT_W-1:0] out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [VAL_W-1:0]  out_time_q;
	logic [VAL_W-1:0]  out_cd_q;
	logic              out_last_q;
	logic              out_free;

	// Memory ports.
	logic [AW-1:0]    raddr;
	logic [VAL_W-1:0] count_rd;
	logic [VAL_W-1:0] reload_rd;
	logic             count_we;
	logic [AW-1:0]    count_waddr;
	logic [VAL_W-1:0] count_wdata;
	logic             reload_we;
	logic [AW-1:0]    reload_waddr;

	// Result to load into the output register.
	logic              emit;
	logic              e_kind;
	logic [STAT_W-1:0] e_status;
	logic [SW-1:0]     e_slot;
	logic [VAL_W-1:0]  e_cd;
	logic              e_last;

	// Command and sweep decisions.
	logic          free_found;
	logic [AW-1:0] free_idx;
	logic          slot_cmd;
	logic          slot_ok;
	logic          cmd_done;
	logic [VAL_W-1:0] cnt_dec;
	logic          active;
	logic          expire;
	logic          stall;
	logic          sweep_end;
	logic          accept;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;

	stb_ram #(.DEPTH(TIMER_SLOTS), .WIDTH(VAL_W), .AW(AW)) u_count (
		.clk   (clk),
		.we    (count_we),
		.waddr (count_waddr),
		.wdata (count_wdata),
		.raddr (raddr),
		.rdata (count_rd)
	);

	stb_ram #(.DEPTH(TIMER_SLOTS), .WIDTH(VAL_W), .AW(AW)) u_reload (
		.clk   (clk),
		.we    (reload_we),
		.waddr (reload_waddr),
		.wdata (val_q),
		.raddr (raddr),
		.rdata (reload_rd)
	);

	// Lowest free slot for create.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = AW'(i);
			end
		end
	end

	// Slot-addressed commands check that the slot is in use.
	assign slot_cmd = (cmd_q == CMD_DELETE) || (cmd_q == CMD_START) ||
		(cmd_q == CMD_STOP) || (cmd_q == CMD_RESET) ||
		(cmd_q == CMD_SET_AUTO) || (cmd_q == CMD_SET_RELOAD);
	assign slot_ok  = idx_ok_q && used_q[idx_q];
	assign cmd_done = (state_q == S_CMD) && out_free;

	// Per-slot tick work on the data returned from the memories.
	assign cnt_dec   = (count_rd != '0) ? count_rd - VAL_W'(1) : '0;
	assign active    = v_s1 && used_q[idx_s1] && en_q[idx_s1];
	assign expire    = active && (cnt_dec == '0);
	assign stall     = expire && !out_free;
	assign sweep_end = (state_q == S_TICK) && !v_s1 && (ptr_q == CW'(TIMER_SLOTS));

	// Read address: the incoming index, the latched index, or the sweep.
	always_comb begin
		raddr = idx_q;
		case (state_q)
			S_IDLE: raddr = in_idx_ext[AW-1:0];
			S_CMD:  raddr = idx_q;
			S_TICK: raddr = stall ? idx_s1 : ptr_q[AW-1:0];
			default: raddr = idx_q;
		endcase
	end

	// Memory writes.
	always_comb begin
		count_we     = 1'b0;
		count_waddr  = idx_q;
		count_wdata  = val_q;
		reload_we    = 1'b0;
		reload_waddr = idx_q;
		if (state_q == S_TICK) begin
			count_we    = active && !stall;
			count_waddr = idx_s1;
			count_wdata = expire ? reload_rd : cnt_dec;
		end else if (cmd_done) begin
			if (cmd_q == CMD_CREATE) begin
				count_we     = free_found;
				count_waddr  = free_idx;
				reload_we    = free_found;
				reload_waddr = free_idx;
			end else if (cmd_q == CMD_RESET) begin
				count_we    = slot_ok;
				count_wdata = reload_rd;
			end else if (cmd_q == CMD_SET_RELOAD) begin
				reload_we = slot_ok;
			end
		end
	end

	// Result selection.
	always_comb begin
		emit     = 1'b0;
		e_kind   = KIND_ACK;
		e_status = STAT_OK;
		e_slot   = '0;
		e_cd     = countdown_q;
		e_last   = 1'b1;
		if (cmd_done) begin
			emit = 1'b1;
			if (cmd_q == CMD_CREATE) begin
				if (free_found) begin
					e_slot = SW'(free_idx);
				end else begin
					e_status = STAT_NO_FREE;
				end
			end else if (slot_cmd && !slot_ok) begin
				e_status = STAT_NOT_USED;
			end else if (cmd_q == CMD_LOAD_CD) begin
				e_cd = val_q;
			end
		end else if (expire && out_free) begin
			emit   = 1'b1;
			e_kind = KIND_EXPIRY;
			e_slot = SW'(idx_s1);
			e_last = 1'b0;
		end else if (sweep_end && out_free) begin
			emit = 1'b1;
		end
	end

	// Sequencer, counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ptr_q        <= '0;
			v_s1         <= 1'b0;
			tick_total_q <= '0;
			countdown_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tuser == CMD_TICK) begin
							tick_total_q <= tick_total_q + VAL_W'(1);
							if (countdown_q != '0) begin
								countdown_q <= countdown_q - VAL_W'(1);
							end
							ptr_q   <= '0;
							v_s1    <= 1'b0;
							state_q <= S_TICK;
						end else begin
							state_q <= S_CMD;
						end
					end
				end
				S_CMD: begin
					if (cmd_done) begin
						if (cmd_q == CMD_LOAD_CD) begin
							countdown_q <= val_q;
						end
						state_q <= S_IDLE;
					end
				end
				S_TICK: begin
					if (!stall) begin
						if (ptr_q != CW'(TIMER_SLOTS)) begin
							ptr_q <= ptr_q + CW'(1);
							v_s1  <= 1'b1;
						end else begin
							v_s1 <= 1'b0;
						end
					end
					if (sweep_end && out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sweep slot index follows the pointer.
	always_ff @(posedge clk) begin
		if (state_q == S_TICK && !stall) begin
			idx_s1 <= ptr_q[AW-1:0];
		end
	end

	// Request latch.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= s_tuser;
			idx_q    <= in_idx_ext[AW-1:0];
			idx_ok_q <= in_idx_ok;
			val_q    <= in_val;
			auto_q   <= in_auto;
			start_q  <= in_start;
		end
	end

	// Per-slot flag bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			en_q      <= '0;
			auto_en_q <= '0;
		end else if (state_q == S_TICK) begin
			if (expire && !stall && !auto_en_q[idx_s1]) begin
				en_q[idx_s1] <= 1'b0;
			end
		end else if (cmd_done) begin
			if (cmd_q == CMD_CREATE) begin
				if (free_found) begin
					used_q[free_idx]    <= 1'b1;
					en_q[free_idx]      <= start_q;
					auto_en_q[free_idx] <= auto_q;
				end
			end else if (slot_ok) begin
				case (cmd_q)
					CMD_DELETE: begin
						used_q[idx_q]    <= 1'b0;
						en_q[idx_q]      <= 1'b0;
						auto_en_q[idx_q] <= 1'b0;
					end
					CMD_START:    en_q[idx_q]      <= 1'b1;
					CMD_STOP:     en_q[idx_q]      <= 1'b0;
					CMD_SET_AUTO: auto_en_q[idx_q] <= auto_q;
					default: ;
				endcase
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q   <= e_kind;
			out_status_q <= e_status;
			out_slot_q   <= e_slot[SLOT_W-1:0];
			out_time_q   <= tick_total_q;
			out_cd_q     <= e_cd;
			out_last_q   <= e_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_cd_q, out_time_q, out_slot_q, out_status_q};

`ifndef ASSERT_OFF
	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result register overwritten");

	// The sweep pointer never runs past the bank.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= CW'(TIMER_SLOTS))
		else $error("sweep pointer out of range");

	// An accepted tick advances the tick counter by one.
	a_tick_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == CMD_TICK) |=>
		tick_total_q == $past(tick_total_q) + VAL_W'(1))
		else $error("tick counter did not advance");

	// Requests are taken only while no sweep is in progress.
	a_idle_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !v_s1 && !stall)
		else $error("request taken during a sweep");
`endif

endmodule

[sv/stb_ram.sv]
module stb_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
	import stb_pkg::*;

	localparam int SLOTS       = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 40;
	localparam int PHASE_ITEMS = 56;

	// Idle percentages per phase: sender, then receiver.
	localparam int SEND_IDLE [3] = '{9, 87, 0};
	localparam int RECV_IDLE [3] = '{87, 9, 0};

	typedef struct {
		logic [CMD_W-1:0] command;
		logic [IDX_W-1:0] timer_index;
		logic [VAL_W-1:0] value;
		logic             auto_reload;
		logic             start_now;
		bit               hold;
		int               phase;
	} timer_req_t;

	typedef struct {
		logic              kind;
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       system_time;
		logic [31:0]       countdown_now;
		logic              last;
	} timer_res_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [CMD_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	timer_req_t request_queue[$];
	timer_res_t pending_results[$];
	bit         drained = 1'b1;
	int         gen_phase = 0;
	int         recv_idle_pct = RECV_IDLE[0];
	int         error_count = 0;
	int         cycle_count = 0;
	int         n_requests = 0;
	int         n_results = 0;
	int         n_expiries = 0;
	int         n_no_free = 0;
	int         n_not_used = 0;
	int         run_expiries = 0;
	int         max_tick_expiries = 0;

	// Shadow copy of the timer bank.
	bit          slot_used [SLOTS];
	bit          count_enabled [SLOTS];
	bit          reload_enabled [SLOTS];
	logic [31:0] reload_value [SLOTS];
	logic [31:0] current_count [SLOTS];
	logic [31:0] tick_total = '0;
	logic [31:0] countdown = '0;

	software_timer_bank_unit #(.TIMER_SLOTS(SLOTS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d %s is %0h, expected %0h",
				n_results, name, got, want));
		end
	endtask

	task automatic push_result(input logic kind, input logic [STAT_W-1:0] status,
			input logic [SLOT_W-1:0] slot);
		timer_res_t r;
		r.kind = kind;
		r.status = status;
		r.slot = slot;
		r.system_time = tick_total;
		r.countdown_now = countdown;
		r.last = (kind == KIND_ACK);
		pending_results.push_back(r);
	endtask

	// Applies one accepted request to the shadow bank and queues its results.
	task automatic advance_timer_bank(input timer_req_t rq);
		int i;
		int idx;
		idx = rq.timer_index;
		if (rq.command == CMD_TICK) begin
			tick_total = tick_total + 1;
			if (countdown != 0)
				countdown = countdown - 1;
			for (i = 0; i < SLOTS; i++) begin
				if (slot_used[i] && count_enabled[i]) begin
					if (current_count[i] != 0)
						current_count[i] = current_count[i] - 1;
					if (current_count[i] == 0) begin
						push_result(KIND_EXPIRY, STAT_OK, SLOT_W'(i));
						current_count[i] = reload_value[i];
						if (!reload_enabled[i])
							count_enabled[i] = 1'b0;
					end
				end
			end
			push_result(KIND_ACK, STAT_OK, '0);
		end else if (rq.command == CMD_CREATE) begin
			for (i = 0; i < SLOTS; i++)
				if (!slot_used[i])
					break;
			if (i == SLOTS) begin
				push_result(KIND_ACK, STAT_NO_FREE, '0);
			end else begin
				slot_used[i] = 1'b1;
				reload_value[i] = rq.value;
				current_count[i] = rq.value;
				reload_enabled[i] = rq.auto_reload;
				count_enabled[i] = rq.start_now;
				push_result(KIND_ACK, STAT_OK, SLOT_W'(i));
			end
		end else if (rq.command >= CMD_DELETE && rq.command <= CMD_SET_RELOAD) begin
			if (!slot_used[idx]) begin
				push_result(KIND_ACK, STAT_NOT_USED, '0);
			end else begin
				case (rq.command)
					CMD_DELETE: begin
						slot_used[idx] = 1'b0;
						count_enabled[idx] = 1'b0;
						reload_enabled[idx] = 1'b0;
					end
					CMD_START: count_enabled[idx] = 1'b1;
					CMD_STOP: count_enabled[idx] = 1'b0;
					CMD_RESET: current_count[idx] = reload_value[idx];
					CMD_SET_AUTO: reload_enabled[idx] = rq.auto_reload;
					default: reload_value[idx] = rq.value;
				endcase
				push_result(KIND_ACK, STAT_OK, '0);
			end
		end else begin
			// Countdown load; unknown codes only acknowledge.
			if (rq.command == CMD_LOAD_CD)
				countdown = rq.value;
			push_result(KIND_ACK, STAT_OK, '0);
		end
	endtask

	task automatic add_request(input logic [CMD_W-1:0] command,
			input logic [IDX_W-1:0] timer_index, input logic [VAL_W-1:0] value,
			input logic auto_reload, input logic start_now, input bit hold);
		timer_req_t rq;
		rq.command = command;
		rq.timer_index = timer_index;
		rq.value = value;
		rq.auto_reload = auto_reload;
		rq.start_now = start_now;
		rq.hold = hold;
		rq.phase = gen_phase;
		request_queue.push_back(rq);
	endtask

	// Random slot index and random flag.
	function automatic logic [IDX_W-1:0] rand_idx();
		return IDX_W'($urandom());
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom());
	endfunction

	// Reload values are mostly short so that timers expire within a few ticks.
	function automatic logic [31:0] pick_reload();
		if ($urandom_range(9) == 0)
			return $urandom();
		return $urandom_range(0, 5);
	endfunction

	// One random stretch of requests: mostly well-formed timer sequences.
	task automatic add_random_sequence();
		int pick;
		int k;
		bit hold;
		pick = $urandom_range(99);
		hold = ($urandom_range(19) == 0);
		if (pick < 45) begin
			add_request(CMD_CREATE, rand_idx(), pick_reload(), rand_bit(), rand_bit(), hold);
			for (k = $urandom_range(0, 2); k > 0; k--) begin
				add_request(CMD_TICK, rand_idx(), $urandom(), rand_bit(), rand_bit(), 1'b0);
			end
			for (k = $urandom_range(0, 2); k > 0; k--) begin
				add_request(CMD_W'(CMD_CREATE + $urandom_range(1, 6)),
					IDX_W'($urandom_range(0, 3)), pick_reload(), rand_bit(), rand_bit(),
					1'b0);
			end
			for (k = $urandom_range(1, 5); k > 0; k--) begin
				add_request(CMD_TICK, rand_idx(), $urandom(), rand_bit(), rand_bit(), 1'b0);
			end
		end else if (pick < 53) begin
			// Fill the bank and overflow it.
			for (k = 0; k <= SLOTS; k++) begin
				add_request(CMD_CREATE, rand_idx(), pick_reload(), rand_bit(),
					rand_bit(), hold && k == 0);
			end
			add_request(CMD_TICK, rand_idx(), $urandom(), rand_bit(), rand_bit(), 1'b0);
		end else if (pick < 65) begin
			for (k = 0; k < 4; k++) begin
				add_request(CMD_DELETE, rand_idx(), $urandom(), rand_bit(), rand_bit(),
					hold && k == 0);
			end
		end else if (pick < 75) begin
			add_request(CMD_LOAD_CD, rand_idx(), pick_reload(), rand_bit(), rand_bit(), hold);
			for (k = $urandom_range(1, 4); k > 0; k--) begin
				add_request(CMD_TICK, rand_idx(), $urandom(), rand_bit(), rand_bit(), 1'b0);
			end
		end else begin
			add_request(CMD_W'($urandom()), rand_idx(), $urandom(), rand_bit(), rand_bit(),
				hold);
		end
	endtask

	// Request driver: a request marked hold waits until every result is back.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (request_queue.size() > 0
					&& !(request_queue[0].hold && (s_tvalid || !drained))
					&& $urandom_range(99) >= SEND_IDLE[request_queue[0].phase]) begin
				timer_req_t rq;
				rq = request_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= rq.command;
				s_tdata <= {2'b00, rq.start_now, rq.auto_reload, rq.value, rq.timer_index};
				recv_idle_pct <= RECV_IDLE[rq.phase];
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result backpressure.
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: predicts on each accepted request, then checks each accepted result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				timer_req_t rq;
				rq.command = s_tuser;
				rq.timer_index = s_tdata[3:0];
				rq.value = s_tdata[35:4];
				rq.auto_reload = s_tdata[36];
				rq.start_now = s_tdata[37];
				advance_timer_bank(rq);
				n_requests++;
			end
			if (m_tvalid && m_tready) begin
				timer_res_t want;
				n_results++;
				if (m_tuser == KIND_EXPIRY) begin
					n_expiries++;
					run_expiries++;
				end else begin
					if (run_expiries > max_tick_expiries)
						max_tick_expiries = run_expiries;
					run_expiries = 0;
					if (m_tdata[1:0] == STAT_NO_FREE)
						n_no_free++;
					if (m_tdata[1:0] == STAT_NOT_USED)
						n_not_used++;
				end
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing expected",
						n_results));
				end else begin
					want = pending_results.pop_front();
					check_field("kind", m_tuser, want.kind);
					check_field("status", m_tdata[1:0], want.status);
					check_field("slot", m_tdata[5:2], want.slot);
					check_field("system_time", m_tdata[37:6], want.system_time);
					check_field("countdown_now", m_tdata[69:38], want.countdown_now);
					check_field("last", m_tlast, want.last);
				end
			end
			drained <= (pending_results.size() == 0);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int k;

		// Directed part: empty bank, zero and full-scale reloads, every command,
		// free slots, unknown codes and a saturating countdown.
		gen_phase = 0;
		add_request(CMD_TICK, 4'h0, 32'h0, 1'b0, 1'b0, 1'b0);
		add_request(CMD_LOAD_CD, 4'h0, 32'd2, 1'b0, 1'b0, 1'b0);
		add_request(CMD_CREATE, 4'h0, 32'd0, 1'b0, 1'b1, 1'b0);
		add_request(CMD_CREATE, 4'h0, 32'd1, 1'b1, 1'b1, 1'b0);
		add_request(CMD_CREATE, 4'hF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
		for (k = 0; k < 3; k++)
			add_request(CMD_TICK, 4'h0, 32'h0, 1'b0, 1'b0, 1'b0);
		for (k = CMD_DELETE; k <= CMD_SET_RELOAD; k++)
			add_request(CMD_W'(k), 4'hF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
		add_request(CMD_SET_RELOAD, 4'd2, 32'd1, 1'b0, 1'b0, 1'b0);
		add_request(CMD_RESET, 4'd2, 32'h0, 1'b0, 1'b0, 1'b0);
		add_request(CMD_SET_AUTO, 4'd2, 32'h0, 1'b0, 1'b0, 1'b0);
		add_request(CMD_START, 4'd2, 32'h0, 1'b0, 1'b0, 1'b0);
		add_request(CMD_TICK, 4'h0, 32'h0, 1'b0, 1'b0, 1'b0);
		add_request(CMD_STOP, 4'd1, 32'h0, 1'b0, 1'b0, 1'b0);
		add_request(CMD_DELETE, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0);
		add_request(CMD_CREATE, 4'h7, 32'd3, 1'b0, 1'b0, 1'b0);
		add_request(4'd9, rand_idx(), $urandom(), rand_bit(), rand_bit(), 1'b0);
		add_request(4'd15, rand_idx(), $urandom(), rand_bit(), rand_bit(), 1'b0);
		add_request(CMD_LOAD_CD, 4'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
		add_request(CMD_TICK, 4'h0, 32'h0, 1'b0, 1'b0, 1'b1);

		// Random part in three idling phases.
		for (gen_phase = 0; gen_phase < 3; gen_phase++) begin
			k = request_queue.size();
			add_request(CMD_TICK, rand_idx(), $urandom(), rand_bit(), rand_bit(), 1'b1);
			while (request_queue.size() - k < PHASE_ITEMS)
				add_random_sequence();
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (request_queue.size() != 0 || s_tvalid || !drained);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		$display("Ran %0d requests, %0d results, %0d expiries (at most %0d on one tick).",
			n_requests, n_results, n_expiries, max_tick_expiries);
		$display("Saw %0d creates on a full bank and %0d requests on free slots.",
			n_no_free, n_not_used);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
